FILE: sv/rectangle_canvas_painter_defines.svh
// assertion helpers for the painter rtl
`ifndef RECTANGLE_CANVAS_PAINTER_DEFINES_SVH
`define RECTANGLE_CANVAS_PAINTER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define RCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rectangle canvas painter check failed");

// next-cycle implication, checked while out of reset
`define RCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rectangle canvas painter check failed");

`endif

FILE: sv/rcp_pkg.sv
package rcp_pkg;

    localparam int MAX_SIDE  = 512;
    localparam int FRAC_BITS = 8;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int SIZE_W    = 10;
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int CHAR_W    = 8;
    localparam int COORD_W   = 19;
    localparam int BOUND_W   = COORD_W + 2;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // input tdata layout, lowest bit first
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int W_LSB      = Y_LSB + COORD_W;
    localparam int H_LSB      = W_LSB + COORD_W;
    localparam int SHAPE_LSB  = H_LSB + COORD_W;
    localparam int PAINT_LSB  = SHAPE_LSB + CHAR_W;
    localparam int COL_LSB    = PAINT_LSB + CHAR_W;
    localparam int ROW_LSB    = COL_LSB + SIDE_W;
    localparam int S_FIELDS_W = ROW_LSB + SIDE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;
    localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;

    localparam logic [SIZE_W-1:0] SIDE_MAX_VAL  = SIZE_W'(MAX_SIDE);
    localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(MAX_SIDE);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(MAX_SIDE);
    localparam logic [CHAR_W-1:0] BG_RESET      = 8'd32;
    localparam logic signed [BOUND_W-1:0] ONE_FIX = BOUND_W'(1 << FRAC_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REJECT  = 2'd1,
        STATUS_OUTSIDE = 2'd2,
        STATUS_SPARE   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BG     = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_DRAW  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_POST  = 5'b10000
    } state_t;

    // rectangle edges in fixed point, latched whenever a command is taken
    typedef struct packed {
        logic signed [BOUND_W-1:0] x_lo;
        logic signed [BOUND_W-1:0] x_lo_in;
        logic signed [BOUND_W-1:0] x_hi_in;
        logic signed [BOUND_W-1:0] x_hi;
        logic signed [BOUND_W-1:0] y_lo;
        logic signed [BOUND_W-1:0] y_lo_in;
        logic signed [BOUND_W-1:0] y_hi_in;
        logic signed [BOUND_W-1:0] y_hi;
        logic                      filled;
    } rect_bounds_t;

endpackage

FILE: sv/rcp_ram.sv
module rcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/rcp_cover.sv
module rcp_cover (
    input  rcp_pkg::rect_bounds_t          bounds,
    input  logic [rcp_pkg::SIDE_W-1:0]     col,
    input  logic [rcp_pkg::SIDE_W-1:0]     row,
    output logic                           hit
);

    localparam int PAD_W = rcp_pkg::BOUND_W - rcp_pkg::SIDE_W - rcp_pkg::FRAC_BITS;

    logic signed [rcp_pkg::BOUND_W-1:0] px;
    logic signed [rcp_pkg::BOUND_W-1:0] py;
    logic in_x, in_y, edge_x, edge_y;

    assign px = $signed({{PAD_W{1'b0}}, col, {rcp_pkg::FRAC_BITS{1'b0}}});
    assign py = $signed({{PAD_W{1'b0}}, row, {rcp_pkg::FRAC_BITS{1'b0}}});

    assign in_x   = (px >= $signed(bounds.x_lo)) && (px <= $signed(bounds.x_hi));
    assign in_y   = (py >= $signed(bounds.y_lo)) && (py <= $signed(bounds.y_hi));
    // closer than one pixel to any edge
    assign edge_x = (px < $signed(bounds.x_lo_in)) || (px > $signed(bounds.x_hi_in));
    assign edge_y = (py < $signed(bounds.y_lo_in)) || (py > $signed(bounds.y_hi_in));

    assign hit = in_x && in_y && (edge_x || edge_y || bounds.filled);

endmodule

FILE: sv/rectangle_canvas_painter.sv
// rectangle canvas painter
// input transactions on s_t*: s_tuser carries the command (clear, draw, read),
// s_tdata the rectangle, shape/paint characters and the pixel to read.
// every command returns exactly one result transaction on m_t*: m_tdata is the
// pixel character (zero except for a good read), m_tuser the status code.
// the canvas is one 512 x 512 byte memory, one access per cycle.
// clear writes all 262144 entries, one per cycle. draw visits every pixel of
// the area in use. read goes through the registered memory read. rejected and
// unused commands go straight to the result. one command is worked on at a
// time; the next is taken as soon as the previous one is done, even if its
// result still waits in the output register. when the receiver stalls, a
// finished result waits until that register frees. reset (aresetn low,
// synchronous) idles the block, drops any pending result and restores width
// 512, height 512 and background character 32; the canvas content is
// undefined until the first clear. cfg_we/cfg_addr/cfg_wdata write the size
// and background registers; writing them only while idle is the user's duty,
// which the block leaves unchecked.
`include "rectangle_canvas_painter_defines.svh"

module rectangle_canvas_painter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rcp_pkg::SIZE_W-1:0]        cfg_wdata,
    // command input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rect_x, rect_y, rect_width, rect_height, shape_char, paint_char,
    // pixel_col, pixel_row, zero fill
    input  logic [rcp_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [rcp_pkg::CMD_W-1:0]         s_tuser,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_value
    output logic [rcp_pkg::CHAR_W-1:0]        m_tdata,
    // status
    output logic [rcp_pkg::STATUS_W-1:0]      m_tuser
);

    localparam logic [rcp_pkg::SIDE_W-1:0] SIDE_LAST = '1;

    rcp_pkg::state_t state_reg, state_next;

    logic [rcp_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [rcp_pkg::CHAR_W-1:0] bg_reg;
    logic [rcp_pkg::SIZE_W-1:0] cw_use, ch_use;

    logic [rcp_pkg::SIDE_W-1:0] col_reg, row_reg;
    rcp_pkg::rect_bounds_t      bounds_reg;
    logic [rcp_pkg::CHAR_W-1:0] ink_reg;

    logic [rcp_pkg::CHAR_W-1:0]   res_value_reg;
    rcp_pkg::status_t             res_status_reg;
    logic                         m_tvalid_reg;
    logic [rcp_pkg::CHAR_W-1:0]   m_value_reg;
    rcp_pkg::status_t             m_status_reg;

    // input fields
    rcp_pkg::cmd_t                      in_cmd;
    logic signed [rcp_pkg::COORD_W-1:0] in_x, in_y, in_w, in_h;
    logic [rcp_pkg::CHAR_W-1:0]         in_shape, in_paint;
    logic [rcp_pkg::SIDE_W-1:0]         in_col, in_row;

    logic                               s_accept;
    logic                               reject;
    logic                               outside;
    rcp_pkg::rect_bounds_t              bounds_new;
    logic signed [rcp_pkg::BOUND_W-1:0] x_ext, y_ext, x2, y2;

    logic                               col_end, row_end;
    logic                               hit;
    logic                               post_load;

    logic                               ram_we;
    logic [rcp_pkg::ADDR_W-1:0]         ram_addr;
    logic [rcp_pkg::CHAR_W-1:0]         ram_wdata, ram_rdata;

    assign in_cmd   = rcp_pkg::cmd_t'(s_tuser);
    assign in_x     = s_tdata[rcp_pkg::X_LSB +: rcp_pkg::COORD_W];
    assign in_y     = s_tdata[rcp_pkg::Y_LSB +: rcp_pkg::COORD_W];
    assign in_w     = s_tdata[rcp_pkg::W_LSB +: rcp_pkg::COORD_W];
    assign in_h     = s_tdata[rcp_pkg::H_LSB +: rcp_pkg::COORD_W];
    assign in_shape = s_tdata[rcp_pkg::SHAPE_LSB +: rcp_pkg::CHAR_W];
    assign in_paint = s_tdata[rcp_pkg::PAINT_LSB +: rcp_pkg::CHAR_W];
    assign in_col   = s_tdata[rcp_pkg::COL_LSB +: rcp_pkg::SIDE_W];
    assign in_row   = s_tdata[rcp_pkg::ROW_LSB +: rcp_pkg::SIDE_W];

    // sizes in use, saturated to 1..MAX_SIDE
    always_comb begin
        cw_use = width_reg;
        if (width_reg == '0) begin
            cw_use = rcp_pkg::SIZE_W'(1);
        end else if (width_reg > rcp_pkg::SIDE_MAX_VAL) begin
            cw_use = rcp_pkg::SIDE_MAX_VAL;
        end
        ch_use = height_reg;
        if (height_reg == '0) begin
            ch_use = rcp_pkg::SIZE_W'(1);
        end else if (height_reg > rcp_pkg::SIDE_MAX_VAL) begin
            ch_use = rcp_pkg::SIDE_MAX_VAL;
        end
    end

    assign s_tready = (state_reg == rcp_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign reject  = (in_w <= 0) || (in_h <= 0) ||
                     ((in_shape != rcp_pkg::SHAPE_FILLED) &&
                      (in_shape != rcp_pkg::SHAPE_OUTLINE));
    assign outside = ({1'b0, in_col} >= cw_use) || ({1'b0, in_row} >= ch_use);

    assign x_ext = rcp_pkg::BOUND_W'(in_x);
    assign y_ext = rcp_pkg::BOUND_W'(in_y);
    assign x2    = x_ext + rcp_pkg::BOUND_W'(in_w);
    assign y2    = y_ext + rcp_pkg::BOUND_W'(in_h);

    always_comb begin
        bounds_new.x_lo    = x_ext;
        bounds_new.x_lo_in = x_ext + rcp_pkg::ONE_FIX;
        bounds_new.x_hi_in = x2 - rcp_pkg::ONE_FIX;
        bounds_new.x_hi    = x2;
        bounds_new.y_lo    = y_ext;
        bounds_new.y_lo_in = y_ext + rcp_pkg::ONE_FIX;
        bounds_new.y_hi_in = y2 - rcp_pkg::ONE_FIX;
        bounds_new.y_hi    = y2;
        bounds_new.filled  = (in_shape == rcp_pkg::SHAPE_FILLED);
    end

    rcp_cover u_cover (
        .bounds (bounds_reg),
        .col    (col_reg),
        .row    (row_reg),
        .hit    (hit)
    );

    // clear sweeps the whole memory, draw only the area in use
    always_comb begin
        if (state_reg == rcp_pkg::ST_CLEAR) begin
            col_end = (col_reg == SIDE_LAST);
            row_end = (row_reg == SIDE_LAST);
        end else begin
            col_end = ({1'b0, col_reg} == cw_use - rcp_pkg::SIZE_W'(1));
            row_end = ({1'b0, row_reg} == ch_use - rcp_pkg::SIZE_W'(1));
        end
    end

    assign post_load = (state_reg == rcp_pkg::ST_POST) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rcp_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_cmd)
                        rcp_pkg::CMD_CLEAR: state_next = rcp_pkg::ST_CLEAR;
                        rcp_pkg::CMD_DRAW:
                            state_next = reject ? rcp_pkg::ST_POST : rcp_pkg::ST_DRAW;
                        rcp_pkg::CMD_READ:
                            state_next = outside ? rcp_pkg::ST_POST : rcp_pkg::ST_READ;
                        default: state_next = rcp_pkg::ST_POST;
                    endcase
                end
            end
            rcp_pkg::ST_CLEAR,
            rcp_pkg::ST_DRAW: begin
                if (col_end && row_end) begin
                    state_next = rcp_pkg::ST_POST;
                end
            end
            rcp_pkg::ST_READ: state_next = rcp_pkg::ST_POST;
            rcp_pkg::ST_POST: begin
                if (post_load) begin
                    state_next = rcp_pkg::ST_IDLE;
                end
            end
            default: state_next = rcp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rcp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            width_reg    <= rcp_pkg::WIDTH_RESET;
            height_reg   <= rcp_pkg::HEIGHT_RESET;
            bg_reg       <= rcp_pkg::BG_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (rcp_pkg::cfg_idx_t'(cfg_addr))
                    rcp_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                    rcp_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                    rcp_pkg::CFG_BG:     bg_reg     <= cfg_wdata[rcp_pkg::CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (post_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_reg        <= '0;
            row_reg        <= '0;
            bounds_reg     <= bounds_new;
            ink_reg        <= in_paint;
            res_value_reg  <= '0;
            res_status_reg <= rcp_pkg::STATUS_OK;
            if ((in_cmd == rcp_pkg::CMD_DRAW) && reject) begin
                res_status_reg <= rcp_pkg::STATUS_REJECT;
            end else if ((in_cmd == rcp_pkg::CMD_READ) && outside) begin
                res_status_reg <= rcp_pkg::STATUS_OUTSIDE;
            end
        end else if ((state_reg == rcp_pkg::ST_CLEAR) || (state_reg == rcp_pkg::ST_DRAW)) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_reg + rcp_pkg::SIDE_W'(1);
            end else begin
                col_reg <= col_reg + rcp_pkg::SIDE_W'(1);
            end
        end else if (state_reg == rcp_pkg::ST_READ) begin
            res_value_reg <= ram_rdata;
        end
        if (post_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // the read address goes out in the accept cycle, data comes back in ST_READ
    assign ram_addr  = (state_reg == rcp_pkg::ST_IDLE) ? {in_row, in_col} : {row_reg, col_reg};
    assign ram_we    = (state_reg == rcp_pkg::ST_CLEAR) ||
                       ((state_reg == rcp_pkg::ST_DRAW) && hit);
    assign ram_wdata = (state_reg == rcp_pkg::ST_CLEAR) ? bg_reg : ink_reg;

    rcp_ram #(
        .WIDTH (rcp_pkg::CHAR_W),
        .DEPTH (rcp_pkg::DEPTH)
    ) u_canvas (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    `RCP_ASSERT_IMP(a_write_only_sweeping, aclk, aresetn, ram_we,
        (state_reg == rcp_pkg::ST_CLEAR) || (state_reg == rcp_pkg::ST_DRAW))
    `RCP_ASSERT_IMP(a_draw_col_in_area, aclk, aresetn, state_reg == rcp_pkg::ST_DRAW,
        ({1'b0, col_reg} < cw_use) && ({1'b0, row_reg} < ch_use))
    `RCP_ASSERT_NXT(a_read_goes_to_memory, aclk, aresetn,
        s_accept && (in_cmd == rcp_pkg::CMD_READ) && !outside,
        state_reg == rcp_pkg::ST_READ)
    `RCP_ASSERT_IMP(a_error_value_zero, aclk, aresetn,
        m_tvalid && (m_status_reg != rcp_pkg::STATUS_OK), m_value_reg == '0)

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import rcp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct {
        cmd_t                       cmd;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  w;
        logic signed [COORD_W-1:0]  h;
        logic [CHAR_W-1:0]          shape;
        logic [CHAR_W-1:0]          ink;
        logic [SIDE_W-1:0]          col;
        logic [SIDE_W-1:0]          row;
    } paint_cmd_t;

    typedef struct {
        logic [CHAR_W-1:0] value;
        status_t           status;
    } pixel_result_t;

    class paint_scoreboard;
        logic [CHAR_W-1:0] pix [DEPTH];
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [CHAR_W-1:0] bg_reg;
        pixel_result_t     pending_pixels [$];
        int                errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            bg_reg     = BG_RESET;
            errors     = 0;
        endfunction

        function int clamp_side(logic [SIZE_W-1:0] v);
            if (v < 1)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return int'(v);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [SIZE_W-1:0] v);
            case (idx)
                CFG_WIDTH:  width_reg = v;
                CFG_HEIGHT: height_reg = v;
                CFG_BG:     bg_reg = v[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit busy();
            return pending_pixels.size() != 0;
        endfunction

        // update the canvas copy and queue the answer for one accepted command
        function void take_command(paint_cmd_t c);
            pixel_result_t r;
            longint x1, y1, x2, y2, px, py, one;
            int cw, ch;
            bit on_edge;
            r.value  = '0;
            r.status = STATUS_OK;
            cw  = clamp_side(width_reg);
            ch  = clamp_side(height_reg);
            one = longint'(1) << FRAC_BITS;
            case (c.cmd)
                CMD_CLEAR: foreach (pix[k]) pix[k] = bg_reg;
                CMD_DRAW: begin
                    if (c.w <= 0 || c.h <= 0 ||
                        (c.shape != SHAPE_FILLED && c.shape != SHAPE_OUTLINE)) begin
                        r.status = STATUS_REJECT;
                    end else begin
                        x1 = c.x;
                        y1 = c.y;
                        x2 = x1 + c.w;
                        y2 = y1 + c.h;
                        for (int j = 0; j < ch; j++) begin
                            py = longint'(j) * one;
                            if (py < y1 || py > y2)
                                continue;
                            for (int i = 0; i < cw; i++) begin
                                px = longint'(i) * one;
                                if (px < x1 || px > x2)
                                    continue;
                                on_edge = (px - x1 < one) || (x2 - px < one) ||
                                          (py - y1 < one) || (y2 - py < one);
                                if (on_edge || c.shape == SHAPE_FILLED)
                                    pix[j * MAX_SIDE + i] = c.ink;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    if (int'(c.col) >= cw || int'(c.row) >= ch)
                        r.status = STATUS_OUTSIDE;
                    else
                        r.value = pix[int'(c.row) * MAX_SIDE + int'(c.col)];
                end
                default: ;
            endcase
            pending_pixels.push_back(r);
        endfunction

        function void check_result(logic [CHAR_W-1:0] value, logic [STATUS_W-1:0] status);
            pixel_result_t e;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, pixel_value %02h status %0d",
                         $time, value, status);
                return;
            end
            e = pending_pixels.pop_front();
            if (value !== e.value) begin
                errors++;
                $display("%0t: pixel_value mismatch, expected %02h, actual %02h",
                         $time, e.value, value);
            end
            if (status !== e.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, e.status, status);
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = CFG_WIDTH;
    logic [SIZE_W-1:0]       cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [CMD_W-1:0]        s_tuser = CMD_CLEAR;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CHAR_W-1:0]       m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    paint_scoreboard sb;
    bit              steady = 1'b0;
    int unsigned     cycle_count = 0;

    rectangle_canvas_painter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 33);
    end

    // outputs are stable from the falling edge up to the accepting rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic paint_cmd_t mk(cmd_t k, int x, int y, int w, int h,
                                      logic [CHAR_W-1:0] shape, logic [CHAR_W-1:0] ink,
                                      int col, int row);
        paint_cmd_t c;
        c.cmd   = k;
        c.x     = COORD_W'(x);
        c.y     = COORD_W'(y);
        c.w     = COORD_W'(w);
        c.h     = COORD_W'(h);
        c.shape = shape;
        c.ink   = ink;
        c.col   = SIDE_W'(col);
        c.row   = SIDE_W'(row);
        return c;
    endfunction

    function automatic paint_cmd_t random_cmd(int cw, int ch);
        paint_cmd_t c;
        int pick;
        c.x     = COORD_W'($urandom);
        c.y     = COORD_W'($urandom);
        c.w     = COORD_W'($urandom);
        c.h     = COORD_W'($urandom);
        c.shape = CHAR_W'($urandom);
        c.ink   = CHAR_W'($urandom);
        c.col   = SIDE_W'($urandom);
        c.row   = SIDE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) begin
            c.cmd = CMD_DRAW;
            if (pick < 42) begin
                // rectangle near the canvas, fractional edges included
                c.shape = $urandom_range(1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                c.x = COORD_W'(int'($urandom_range(0, (cw + 4) * 256)) - 512);
                c.y = COORD_W'(int'($urandom_range(0, (ch + 4) * 256)) - 512);
                c.w = COORD_W'($urandom_range(1, (cw + 2) * 256));
                c.h = COORD_W'($urandom_range(1, (ch + 2) * 256));
            end else if (pick < 46) begin
                // zero or negative size
                c.shape = $urandom_range(1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                c.w = COORD_W'($urandom_range(1, (cw + 2) * 256));
                c.h = COORD_W'($urandom_range(1, (ch + 2) * 256));
                if ($urandom_range(1))
                    c.w = COORD_W'(-int'($urandom_range(0, 2000)));
                else
                    c.h = COORD_W'(-int'($urandom_range(0, 2000)));
            end else if ($urandom_range(1)) begin
                c.shape = SHAPE_FILLED;
            end
        end else if (pick < 94) begin
            c.cmd = CMD_READ;
            if ($urandom_range(9) < 7) begin
                c.col = SIDE_W'($urandom_range(0, cw - 1));
                c.row = SIDE_W'($urandom_range(0, ch - 1));
            end
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    task automatic push_command(input paint_cmd_t c);
        logic [S_TDATA_W-1:0] d;
        bit took;
        d = '0;
        d[X_LSB +: COORD_W]     = c.x;
        d[Y_LSB +: COORD_W]     = c.y;
        d[W_LSB +: COORD_W]     = c.w;
        d[H_LSB +: COORD_W]     = c.h;
        d[SHAPE_LSB +: CHAR_W]  = c.shape;
        d[PAINT_LSB +: CHAR_W]  = c.ink;
        d[COL_LSB +: SIDE_W]    = c.col;
        d[ROW_LSB +: SIDE_W]    = c.row;
        if (!steady && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= c.cmd;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        sb.take_command(c);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (sb.busy())
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // back-to-back register writes, the unused index last
    task automatic program_canvas(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv,
                                  input logic [SIZE_W-1:0] bgv);
        cfg_idx_t          idx [4] = '{CFG_WIDTH, CFG_HEIGHT, CFG_BG, CFG_NONE};
        logic [SIZE_W-1:0] val [4];
        val = '{wv, hv, bgv, SIZE_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_wdata <= val[k];
            @(posedge aclk);
            sb.set_reg(idx[k], val[k]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        paint_cmd_t c;
        int cw, ch, clear_phase, clear_slot;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full size at reset values, canvas cleared before any read
        push_command(mk(CMD_CLEAR, 0, 0, 0, 0, 8'h00, 8'h00, 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 511, 511));
        push_command(mk(CMD_DRAW, 0, 0, 0, 512, SHAPE_FILLED, "A", 0, 0));
        push_command(mk(CMD_DRAW, 256, 256, 512, -1, SHAPE_OUTLINE, "B", 0, 0));
        // shape byte that is neither filled nor outline
        push_command(mk(CMD_DRAW, 0, 0, 512, 512, "x", "C", 0, 0));
        push_command(mk(CMD_UNUSED, -1, -1, -1, -1, 8'hff, 8'hff, 511, 511));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 511, 0));
        settle_block();

        // width above range saturates, height zero acts as one, bg upper bits dropped
        program_canvas(10'd1023, 10'd0, 10'h3a5);
        push_command(mk(CMD_DRAW, -512, 0, 600 * 256, 256, SHAPE_FILLED, "=", 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 511, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 1));
        push_command(mk(CMD_DRAW, -262144, -262144, 262143, 262143, SHAPE_FILLED, "@", 0, 0));
        push_command(mk(CMD_DRAW, 0, 0, 262143, 262143, SHAPE_OUTLINE, "+", 0, 0));
        push_command(mk(CMD_DRAW, 262143, 0, 1, 256, SHAPE_FILLED, "!", 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 300, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 0));
        settle_block();

        // single column, old content keeps its place
        program_canvas(10'd1, 10'd512, 10'h02e);
        push_command(mk(CMD_DRAW, 0, 'h180, 'h40, 'ha00, SHAPE_OUTLINE, "o", 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 2));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 12));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 1, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 511));
        settle_block();

        // outline over a filled block keeps the interior
        program_canvas(10'd8, 10'd8, 10'h02e);
        push_command(mk(CMD_DRAW, 256, 256, 5 * 256, 5 * 256, SHAPE_FILLED, "#", 0, 0));
        push_command(mk(CMD_DRAW, 0, 0, 7 * 256, 7 * 256, SHAPE_OUTLINE, "*", 0, 0));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 3, 3));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 4));
        push_command(mk(CMD_READ, 0, 0, 0, 0, 8'h00, 8'h00, 7, 7));

        // random part on small canvases, one clear somewhere since it is slow
        clear_phase = $urandom_range(3);
        clear_slot  = $urandom_range(18);
        for (int ph = 0; ph < 4; ph++) begin
            cw = $urandom_range(1, 20);
            ch = $urandom_range(1, 20);
            settle_block();
            program_canvas(SIZE_W'(cw), SIZE_W'(ch), SIZE_W'($urandom));
            steady = (ph == 2);
            for (int n = 0; n < 19; n++) begin
                c = random_cmd(cw, ch);
                if (ph == clear_phase && n == clear_slot)
                    c.cmd = CMD_CLEAR;
                push_command(c);
            end
        end
        steady = 1'b0;

        settle_block();
        repeat (16) @(posedge aclk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: rectangle_canvas_painter.f
+incdir+sv
sv/rcp_pkg.sv
sv/rcp_ram.sv
sv/rcp_cover.sv
sv/rectangle_canvas_painter.sv
verif/tb.sv
